// ===== design/btff_pkg.sv =====
// shared types, sizes and codes for the boundary-tag first-fit allocator
`timescale 1ns / 1ps

package btff_pkg;

   // heap geometry, settled by the fixed widths of the offset and size fields
   localparam int HEAP_WORDS = 1024;
   localparam int ADDR_W     = 10;
   localparam int SIZE_W     = 11;
   localparam int TAG_W      = SIZE_W + 1;
   localparam int FBT_W      = 10;
   localparam int REQ_W      = 10;

   localparam logic [SIZE_W-1:0] HEAP_SIZE = SIZE_W'(HEAP_WORDS);

   // stream payload layout
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 48;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NO_FIT   = 2'd1,
      ST_BAD_FREE = 2'd2
   } status_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [TAG_W-1:0]  data;
   } tag_wr_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] block_offset;
      logic [SIZE_W-1:0] total_free;
      logic [FBT_W-1:0]  free_blocks;
      logic [SIZE_W-1:0] max_free_estimate;
   } res_type;

endpackage

// ===== design/btff_tag_ram.sv =====
// tag memory: one header/footer word per heap word, registered read
`timescale 1ns / 1ps

module btff_tag_ram import btff_pkg::*; (
   input  logic              clock,
   input  tag_wr_type        wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [TAG_W-1:0]  rd_data_ff
);

   logic [TAG_W-1:0] tag_mem [HEAP_WORDS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         tag_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= tag_mem[rd_addr];
   end

endmodule

// ===== design/btff_div.sv =====
// restoring divider, one quotient bit a cycle
`timescale 1ns / 1ps

module btff_div import btff_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SIZE_W-1:0] dividend,
   input  logic [FBT_W-1:0]  divisor,
   output logic              busy,
   output logic              done,
   output logic [SIZE_W-1:0] quotient
);

   localparam int CNT_W = $clog2(SIZE_W + 1);

   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] quo_ff, quo_in;
   logic [FBT_W-1:0]  div_ff, div_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SIZE_W-1:0] rem_sh;
   logic [SIZE_W-1:0] div_ext;

   assign rem_sh  = {rem_ff[SIZE_W-2:0], quo_ff[SIZE_W-1]};
   assign div_ext = SIZE_W'(div_ff);

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = CNT_W'(SIZE_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= div_ext) begin
            rem_in = rem_sh - div_ext;
            quo_in = {quo_ff[SIZE_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[SIZE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/btff_ctrl.sv =====
// sequencer: block walk, tag rewrites, counters and estimate update
`timescale 1ns / 1ps

module btff_ctrl import btff_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  logic              command,
   input  logic [REQ_W-1:0]  request_words,
   input  logic [ADDR_W-1:0] free_offset,
   output logic              res_valid,
   input  logic              res_take,
   output res_type           res
);

   typedef enum logic [14:0] {
      S_INIT0  = 15'b000000000000001,
      S_INIT1  = 15'b000000000000010,
      S_IDLE   = 15'b000000000000100,
      S_AWALK  = 15'b000000000001000,
      S_AW1    = 15'b000000000010000,
      S_AW2    = 15'b000000000100000,
      S_AW3    = 15'b000000001000000,
      S_FWALK  = 15'b000000010000000,
      S_FRP    = 15'b000000100000000,
      S_FPV    = 15'b000001000000000,
      S_FWF    = 15'b000010000000000,
      S_DSTART = 15'b000100000000000,
      S_DIV    = 15'b001000000000000,
      S_DONE   = 15'b010000000000000,
      S_SPARE  = 15'b100000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] pos_ff, pos_in;
   logic [SIZE_W-1:0] need_ff, need_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] cur_ff, cur_in;
   logic [ADDR_W-1:0] off_ff, off_in;
   logic [ADDR_W-1:0] hdr_ff, hdr_in;
   logic              nxt_ok_ff, nxt_ok_in;
   logic              cmd_ff, cmd_in;
   status_type        status_ff, status_in;
   logic [SIZE_W-1:0] fwt_ff, fwt_in;
   logic [FBT_W-1:0]  fbt_ff, fbt_in;
   logic [SIZE_W-1:0] guess_ff, guess_in;

   tag_wr_type        tag_wr;
   logic [ADDR_W-1:0] rd_addr;
   logic [TAG_W-1:0]  rd_data_ff;
   logic [SIZE_W-1:0] tag_size;
   logic              tag_used;
   logic [SIZE_W-1:0] pos_sum;
   logic [SIZE_W-1:0] off_ext;
   logic [SIZE_W-1:0] nxt_pos;
   logic [SIZE_W-1:0] addr_calc;
   logic              prev_merge;

   logic              div_start;
   logic              div_busy;
   logic              div_done;
   logic [SIZE_W-1:0] div_quo;

   btff_tag_ram u_tag_ram (
      .clock      (clock),
      .wr         (tag_wr),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data_ff)
   );

   btff_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (fwt_ff),
      .divisor  (fbt_ff + FBT_W'(1)),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign tag_size = rd_data_ff[TAG_W-1:1];
   assign tag_used = rd_data_ff[0];
   assign pos_sum  = pos_ff + tag_size;
   assign off_ext  = SIZE_W'(off_ff);
   assign nxt_pos  = off_ext + tag_size;
   assign prev_merge = (off_ff != '0) && !tag_used && (tag_size != '0)
                       && (tag_size <= off_ext);

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      need_in   = need_ff;
      size_in   = size_ff;
      cur_in    = cur_ff;
      off_in    = off_ff;
      hdr_in    = hdr_ff;
      nxt_ok_in = nxt_ok_ff;
      cmd_in    = cmd_ff;
      status_in = status_ff;
      fwt_in    = fwt_ff;
      fbt_in    = fbt_ff;
      guess_in  = guess_ff;
      tag_wr    = '0;
      rd_addr   = '0;
      addr_calc = '0;
      div_start = 1'b0;
      unique case (state_ff)
         S_INIT0: begin
            tag_wr.en   = 1'b1;
            tag_wr.addr = '0;
            tag_wr.data = {HEAP_SIZE, 1'b0};
            state_in    = S_INIT1;
         end
         S_INIT1: begin
            tag_wr.en   = 1'b1;
            tag_wr.addr = ADDR_W'(HEAP_WORDS - 1);
            tag_wr.data = {HEAP_SIZE, 1'b0};
            state_in    = S_IDLE;
         end
         S_IDLE: begin
            // word 0 is read here so that the walk starts with its tag in hand
            if (cmd_valid) begin
               cmd_in    = command;
               need_in   = SIZE_W'(request_words) + SIZE_W'(2);
               off_in    = free_offset;
               pos_in    = '0;
               status_in = ST_DONE;
               state_in  = (command == CMD_FREE) ? S_FWALK : S_AWALK;
            end
         end
         S_AWALK: begin
            if (tag_size == '0) begin
               status_in = ST_NO_FIT;
               state_in  = S_DONE;
            end else if (!tag_used && tag_size >= need_ff) begin
               tag_wr.en   = 1'b1;
               tag_wr.addr = pos_ff[ADDR_W-1:0];
               tag_wr.data = {need_ff, 1'b1};
               size_in     = tag_size;
               fwt_in      = fwt_ff - need_ff;
               if (need_ff == tag_size) begin
                  fbt_in = fbt_ff - FBT_W'(1);
               end
               if (tag_size == guess_ff) begin
                  guess_in = guess_ff - need_ff;
               end
               state_in = S_AW1;
            end else if (pos_sum >= HEAP_SIZE) begin
               status_in = ST_NO_FIT;
               state_in  = S_DONE;
            end else begin
               pos_in  = pos_sum;
               rd_addr = pos_sum[ADDR_W-1:0];
            end
         end
         S_AW1: begin
            addr_calc   = pos_ff + need_ff - SIZE_W'(1);
            tag_wr.en   = 1'b1;
            tag_wr.addr = addr_calc[ADDR_W-1:0];
            tag_wr.data = {need_ff, 1'b1};
            state_in    = (need_ff < size_ff) ? S_AW2 : S_DSTART;
         end
         S_AW2: begin
            // remainder header, may be a one-word block
            addr_calc   = pos_ff + need_ff;
            tag_wr.en   = 1'b1;
            tag_wr.addr = addr_calc[ADDR_W-1:0];
            tag_wr.data = {size_ff - need_ff, 1'b0};
            state_in    = S_AW3;
         end
         S_AW3: begin
            addr_calc   = pos_ff + size_ff - SIZE_W'(1);
            tag_wr.en   = 1'b1;
            tag_wr.addr = addr_calc[ADDR_W-1:0];
            tag_wr.data = {size_ff - need_ff, 1'b0};
            state_in    = S_DSTART;
         end
         S_FWALK: begin
            if (pos_ff < off_ext) begin
               if (tag_size == '0) begin
                  status_in = ST_BAD_FREE;
                  state_in  = S_DONE;
               end else begin
                  pos_in  = pos_sum;
                  rd_addr = pos_sum[ADDR_W-1:0];
               end
            end else if (pos_ff == off_ext && tag_used && tag_size != '0) begin
               cur_in    = tag_size;
               fwt_in    = fwt_ff + tag_size;
               fbt_in    = fbt_ff + FBT_W'(1);
               rd_addr   = nxt_pos[ADDR_W-1:0];
               nxt_ok_in = (nxt_pos < HEAP_SIZE);
               state_in  = S_FRP;
            end else begin
               status_in = ST_BAD_FREE;
               state_in  = S_DONE;
            end
         end
         S_FRP: begin
            // next neighbour tag arrives, previous footer is fetched
            if (nxt_ok_ff && !tag_used) begin
               cur_in = cur_ff + tag_size;
               fbt_in = fbt_ff - FBT_W'(1);
            end
            rd_addr  = off_ff - ADDR_W'(1);
            state_in = S_FPV;
         end
         S_FPV: begin
            if (prev_merge) begin
               hdr_in = off_ff - tag_size[ADDR_W-1:0];
               cur_in = cur_ff + tag_size;
               fbt_in = fbt_ff - FBT_W'(1);
            end else begin
               hdr_in = off_ff;
            end
            tag_wr.en   = 1'b1;
            tag_wr.addr = hdr_in;
            tag_wr.data = {cur_in, 1'b0};
            state_in    = S_FWF;
         end
         S_FWF: begin
            addr_calc   = SIZE_W'(hdr_ff) + cur_ff - SIZE_W'(1);
            tag_wr.en   = 1'b1;
            tag_wr.addr = addr_calc[ADDR_W-1:0];
            tag_wr.data = {cur_ff, 1'b0};
            if (cur_ff > guess_ff) begin
               guess_in = cur_ff;
            end
            state_in = S_DSTART;
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               if (div_quo > guess_ff) begin
                  guess_in = div_quo;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT0;
         fwt_ff   <= HEAP_SIZE;
         fbt_ff   <= FBT_W'(1);
         guess_ff <= HEAP_SIZE;
      end else begin
         state_ff <= state_in;
         fwt_ff   <= fwt_in;
         fbt_ff   <= fbt_in;
         guess_ff <= guess_in;
      end
      pos_ff    <= pos_in;
      need_ff   <= need_in;
      size_ff   <= size_in;
      cur_ff    <= cur_in;
      off_ff    <= off_in;
      hdr_ff    <= hdr_in;
      nxt_ok_ff <= nxt_ok_in;
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
   end

   assign cmd_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   always_comb begin
      res.status            = status_ff;
      res.block_offset      = (cmd_ff == CMD_ALLOC && status_ff == ST_DONE)
                              ? pos_ff[ADDR_W-1:0] : '0;
      res.total_free        = fwt_ff;
      res.free_blocks       = fbt_ff;
      res.max_free_estimate = guess_ff;
   end

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_free_total_bound: assert property (@(posedge clock) disable iff (reset)
      fwt_ff <= HEAP_SIZE)
      else $error("free word total beyond heap size");

   a_no_blocks_no_words: assert property (@(posedge clock) disable iff (reset)
      (fbt_ff == '0) |-> (fwt_ff == '0))
      else $error("free words counted without a free block");

   a_no_words_no_blocks: assert property (@(posedge clock) disable iff (reset)
      (fwt_ff == '0) |-> (fbt_ff == '0))
      else $error("free block counted without free words");

   a_result_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_done) |=> res_valid && status_ff == ST_DONE)
      else $error("estimate update did not end in a good result");

endmodule

// ===== design/boundary_tag_first_fit_allocator_unit.sv =====
// top level of the boundary-tag first-fit allocator with result register
`timescale 1ns / 1ps

// Heap allocator over a 1024-word boundary-tag store. Commands arrive on the
// req_ stream: tuser is the command (0 allocate, 1 free), tdata carries the
// requested data words and the header offset to free. Every command gives one
// item on the rsp_ stream: tuser is the status (done, no fit, bad free) and
// tdata the allocated header offset, free word count, free block count and
// the largest-free-block estimate.
// One command is in flight at a time; req_tready is high while the sequencer
// waits for a command. Blocks are walked from offset 0, one tag read per cycle
// on the single tag memory port; then come the tag rewrites (more of them when
// an allocate splits a block) and the bit-serial divider behind the estimate,
// before the result reaches the output register. Failed commands skip the tag
// rewrites and the divider. The next command can be taken in the cycle after
// the result has left the sequencer.
// After reset the block writes the header and footer of the single free block
// that spans the heap, in S_INIT0 and S_INIT1, and takes no command meanwhile.
// The result sits in an output register: while the receiver stalls the next
// command is still accepted and worked on, and its result waits until the
// register is taken.

module boundary_tag_first_fit_allocator_unit import btff_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // request_words, free_offset
   input  logic                   req_tuser,  // command
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // block_offset, total_free,
                                              // free_blocks, max_free_estimate
   output logic [1:0]             rsp_tuser   // status
);

   logic    res_valid;
   logic    res_take;
   res_type res;
   logic    out_free;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]             rsp_user_ff, rsp_user_in;

   btff_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (req_tvalid),
      .cmd_ready     (req_tready),
      .command       (req_tuser),
      .request_words (req_tdata[REQ_W-1:0]),
      .free_offset   (req_tdata[REQ_W+ADDR_W-1:REQ_W]),
      .res_valid     (res_valid),
      .res_take      (res_take),
      .res           (res)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign res_take = res_valid && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = res.status;
         rsp_data_in  = RSP_TDATA_W'({res.max_free_estimate, res.free_blocks,
                                      res.total_free, res.block_offset});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== tb/boundary_tag_first_fit_allocator_unit_tb.sv =====
// testbench for the boundary-tag first-fit allocator: heap traffic checked against a predictor
`timescale 1ns / 1ps

module boundary_tag_first_fit_allocator_unit_tb import btff_pkg::*; ();

   localparam int STALL_PCT      = 22;
   localparam int RANDOM_ITEMS   = 800;
   localparam int WATCHDOG_LIMIT = 8000;
   localparam int TAIL_CYCLES    = 40;

   class alloc_scoreboard;
      int unsigned tag_words [HEAP_WORDS];
      int unsigned free_words;
      int unsigned free_count;
      int unsigned largest_guess;
      int unsigned live_offsets [$];
      int unsigned last_freed;
      res_type     pending_results [$];
      int unsigned fail_count;

      function new();
         foreach (tag_words[i]) tag_words[i] = 0;
         tag_words[0]            = HEAP_WORDS << 1;
         tag_words[HEAP_WORDS-1] = HEAP_WORDS << 1;
         free_words    = HEAP_WORDS;
         free_count    = 1;
         largest_guess = HEAP_WORDS;
         last_freed    = 0;
         fail_count    = 0;
      endfunction

      function void write_tag(int unsigned idx, int unsigned val);
         if (idx < HEAP_WORDS) tag_words[idx] = val;
      endfunction

      // lift the estimate to a floor, then to the free words over one more than the free blocks
      function void raise_guess(int unsigned floor_val);
         if (floor_val > largest_guess) largest_guess = floor_val;
         if (free_words / (free_count + 1) > largest_guess)
            largest_guess = free_words / (free_count + 1);
      endfunction

      function status_type carve_block(int unsigned words, output int unsigned offset);
         int unsigned need;
         int unsigned pos;
         int unsigned t;
         int unsigned s;
         need   = words + 2;
         pos    = 0;
         offset = 0;
         while (pos < HEAP_WORDS) begin
            t = tag_words[pos];
            s = t >> 1;
            if (s == 0) break;
            if ((t & 1) == 0 && s >= need) begin
               write_tag(pos, (need << 1) | 1);
               write_tag(pos + need - 1, (need << 1) | 1);
               // remainder may be a single word whose header is its footer
               if (need < s) begin
                  write_tag(pos + need, (s - need) << 1);
                  write_tag(pos + s - 1, (s - need) << 1);
               end
               free_words -= need;
               if (need == s) free_count -= 1;
               if (s == largest_guess) largest_guess -= need;
               raise_guess(0);
               offset = pos;
               live_offsets.push_back(pos);
               return ST_DONE;
            end
            pos += s;
         end
         return ST_NO_FIT;
      endfunction

      function status_type release_block(int unsigned off);
         int unsigned pos;
         int unsigned s;
         int unsigned cur;
         int unsigned nxt;
         int unsigned ps;
         if (off >= HEAP_WORDS) return ST_BAD_FREE;
         pos = 0;
         while (pos < off) begin
            s = tag_words[pos] >> 1;
            if (s == 0) return ST_BAD_FREE;
            pos += s;
         end
         if (pos != off || (tag_words[off] & 1) == 0 || (tag_words[off] >> 1) == 0)
            return ST_BAD_FREE;
         cur = tag_words[off] >> 1;
         write_tag(off, cur << 1);
         write_tag(off + cur - 1, cur << 1);
         free_words += cur;
         free_count += 1;
         nxt = off + cur;
         if (nxt < HEAP_WORDS && (tag_words[nxt] & 1) == 0) begin
            cur += tag_words[nxt] >> 1;
            write_tag(off, cur << 1);
            write_tag(off + cur - 1, cur << 1);
            free_count -= 1;
         end
         // previous neighbour found through its footer
         if (off != 0 && (tag_words[off-1] & 1) == 0) begin
            ps = tag_words[off-1] >> 1;
            if (ps != 0 && ps <= off) begin
               write_tag(off - ps, (ps + cur) << 1);
               write_tag(off + cur - 1, (ps + cur) << 1);
               cur += ps;
               free_count -= 1;
            end
         end
         raise_guess(cur);
         foreach (live_offsets[i])
            if (live_offsets[i] == off) begin
               live_offsets.delete(i);
               break;
            end
         last_freed = off;
         return ST_DONE;
      endfunction

      function void note_command(logic cmd, logic [REQ_W-1:0] words,
                                 logic [ADDR_W-1:0] off);
         res_type     want;
         int unsigned where;
         where = 0;
         if (cmd == CMD_ALLOC) want.status = carve_block(32'(words), where);
         else want.status = release_block(32'(off));
         want.block_offset      = ADDR_W'(where);
         want.total_free        = SIZE_W'(free_words);
         want.free_blocks       = FBT_W'(free_count);
         want.max_free_estimate = SIZE_W'(largest_guess);
         pending_results.push_back(want);
      endfunction

      function void check_result(res_type got);
         res_type want;
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: result with nothing pending: st=%0d off=%0d", $realtime,
                        got.status, got.block_offset);
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.block_offset !== want.block_offset ||
             got.total_free !== want.total_free || got.free_blocks !== want.free_blocks ||
             got.max_free_estimate !== want.max_free_estimate) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: exp st=%0d off=%0d tot=%0d blk=%0d est=%0d",
                        $realtime, want.status, want.block_offset, want.total_free,
                        want.free_blocks, want.max_free_estimate,
                        " / got st=%0d off=%0d tot=%0d blk=%0d est=%0d",
                        got.status, got.block_offset, got.total_free, got.free_blocks,
                        got.max_free_estimate);
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;

   bit              steady = 1'b0;
   int unsigned     quiet_cycles = 0;
   res_type         rsp_item;
   alloc_scoreboard heap_sb;

   boundary_tag_first_fit_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_item.status            = status_type'(rsp_tuser);
            rsp_item.block_offset      = rsp_tdata[9:0];
            rsp_item.total_free        = rsp_tdata[20:10];
            rsp_item.free_blocks       = rsp_tdata[30:21];
            rsp_item.max_free_estimate = rsp_tdata[41:31];
            heap_sb.check_result(rsp_item);
         end
         rsp_tready <= steady || ($urandom_range(99) >= STALL_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_cmd(logic cmd, logic [REQ_W-1:0] words, logic [ADDR_W-1:0] off);
      while (!steady && $urandom_range(99) < STALL_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_TDATA_W'({off, words});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      heap_sb.note_command(cmd, words, off);
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (heap_sb.pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned roll;
      int unsigned alloc_pct;
      logic [REQ_W-1:0] words;
      heap_sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // free of the spanning free block, free of a non-header offset
      push_cmd(CMD_FREE, 10'h3FF, 10'd0);
      push_cmd(CMD_FREE, 10'h155, 10'd1023);
      // whole heap in one block, then nothing fits
      push_cmd(CMD_ALLOC, 10'd1022, 10'h3FF);
      push_cmd(CMD_ALLOC, 10'd0, 10'h2AA);
      push_cmd(CMD_FREE, 10'h3FF, 10'd0);
      // leave a one-word remainder at the top of the heap
      push_cmd(CMD_ALLOC, 10'd0, 10'd0);
      push_cmd(CMD_ALLOC, 10'd1019, 10'h155);
      push_cmd(CMD_FREE, 10'd0, 10'd1023);
      push_cmd(CMD_ALLOC, 10'd0, 10'd0);
      push_cmd(CMD_FREE, 10'd0, 10'd2);
      // three small blocks, freed so that every kind of merge happens
      push_cmd(CMD_ALLOC, 10'd5, 10'd0);
      push_cmd(CMD_ALLOC, 10'd5, 10'd0);
      push_cmd(CMD_ALLOC, 10'd5, 10'd0);
      push_cmd(CMD_FREE, 10'd0, 10'd9);
      push_cmd(CMD_FREE, 10'd0, 10'd12);
      push_cmd(CMD_FREE, 10'd0, 10'd2);
      push_cmd(CMD_FREE, 10'd0, 10'd0);
      push_cmd(CMD_FREE, 10'd0, 10'd16);
      // request beyond the heap, then the largest request that fits
      push_cmd(CMD_ALLOC, 10'd1023, 10'd0);
      push_cmd(CMD_ALLOC, 10'd1022, 10'd0);
      push_cmd(CMD_FREE, 10'd0, 10'd0);
      push_cmd(CMD_FREE, 10'd0, 10'd0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady <= (i >= 300 && i < 450);
         if (i % 200 == 199) wait_all_results();
         // lean towards frees when the heap runs short
         alloc_pct = (heap_sb.free_words < 128) ? 30 : 50;
         roll = $urandom_range(99);
         if (heap_sb.live_offsets.size() == 0 || roll < alloc_pct) begin
            roll = $urandom_range(99);
            if (roll < 75) words = REQ_W'($urandom_range(24));
            else if (roll < 95) words = REQ_W'($urandom_range(200, 25));
            else words = REQ_W'($urandom_range(1023, 201));
            push_cmd(CMD_ALLOC, words, ADDR_W'($urandom_range(1023)));
         end else if (roll < 88) begin
            push_cmd(CMD_FREE, REQ_W'($urandom_range(1023)),
                     ADDR_W'(heap_sb.live_offsets[
                        $urandom_range(heap_sb.live_offsets.size() - 1)]));
         end else if (roll < 94) begin
            push_cmd(CMD_FREE, REQ_W'($urandom_range(1023)),
                     ADDR_W'(heap_sb.last_freed));
         end else begin
            push_cmd(CMD_FREE, REQ_W'($urandom_range(1023)),
                     ADDR_W'($urandom_range(1023)));
         end
      end

      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (heap_sb.fail_count == 0 && heap_sb.pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
